### hdl/ipv4rl_pkg.sv
// ----------------------------------------------------------------------------
// ipv4rl_pkg
// Shared types and constants for the IPv4 header parser and route lookup.
// ----------------------------------------------------------------------------
package ipv4rl_pkg;

    localparam int ROUTES_DEFAULT = 64;

    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 16;
    localparam int RIDX_W    = 6;
    localparam int RCOUNT_W  = 7;

    localparam logic [LEN_W-1:0] HDR_BYTES = 16'd20;

    // header byte offsets
    localparam logic [LEN_W-1:0] POS_LEN_HI  = 16'd2;
    localparam logic [LEN_W-1:0] POS_LEN_LO  = 16'd3;
    localparam logic [LEN_W-1:0] POS_TTL     = 16'd8;
    localparam logic [LEN_W-1:0] POS_SRC_LO  = 16'd12;
    localparam logic [LEN_W-1:0] POS_SRC_HI  = 16'd15;
    localparam logic [LEN_W-1:0] POS_DST_LO  = 16'd16;
    localparam logic [LEN_W-1:0] POS_LAST    = 16'd19;

    // operation codes
    localparam logic OP_PACKET_BYTE = 1'b0;
    localparam logic OP_ROUTE_WRITE = 1'b1;

    // configuration register map
    localparam int               APB_ADDR_W      = 2;
    localparam logic [APB_ADDR_W-1:0] REG_ROUTE_COUNT = 2'd0;

    // job queue between parser and lookup engine
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic                  is_route;
        logic [RIDX_W-1:0]     index;
        logic [ADDR_W-1:0]     word_a;   // prefix or source address
        logic [ADDR_W-1:0]     word_b;   // mask or destination address
        logic [ADDR_W-1:0]     word_c;   // next hop
        logic [BYTE_W-1:0]     ttl;
        logic [LEN_W-1:0]      length;
    } job_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] hop;
    } route_t;

    typedef enum logic [1:0] {
        LK_IDLE,
        LK_SCAN,
        LK_DRAIN,
        LK_DONE
    } lookup_state_t;

endpackage

### hdl/ipv4rl_parser.sv
// ----------------------------------------------------------------------------
// ipv4rl_parser
// Front end: accepts route writes and packet bytes, walks the fixed 20-byte
// header, and queues route writes and lookup jobs for the back end.
// ----------------------------------------------------------------------------
module ipv4rl_parser #(
    parameter int ROUTES = ipv4rl_pkg::ROUTES_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_operation,
    input  logic [ipv4rl_pkg::BYTE_W-1:0] s_data_byte,
    input  logic [ipv4rl_pkg::RIDX_W-1:0] s_route_index,
    input  logic [ipv4rl_pkg::ADDR_W-1:0] s_route_prefix,
    input  logic [ipv4rl_pkg::ADDR_W-1:0] s_route_mask,
    input  logic [ipv4rl_pkg::ADDR_W-1:0] s_route_next_hop,
    output logic                        job_valid,
    input  logic                        job_ready,
    output ipv4rl_pkg::job_t            job
);
    import ipv4rl_pkg::*;

    localparam int CW = ($clog2(ROUTES + 1) > RCOUNT_W) ? $clog2(ROUTES + 1) : RCOUNT_W;

    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] ttl_reg, ttl_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [LEN_W:0]    pos_inc;
    logic              accept;
    logic              index_ok;

    assign s_ready  = job_ready;
    assign accept   = s_valid & s_ready;
    assign pos_inc  = {1'b0, pos_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign index_ok = CW'(s_route_index) < CW'(ROUTES);

    always_comb begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        ttl_next  = ttl_reg;
        src_next  = src_reg;
        dst_next  = dst_reg;
        job_valid = 1'b0;
        job       = '0;
        if (accept) begin
            if (s_operation == OP_ROUTE_WRITE) begin
                // writes past the table are dropped here
                job_valid    = index_ok;
                job.is_route = 1'b1;
                job.index    = s_route_index;
                job.word_a   = s_route_prefix;
                job.word_b   = s_route_mask;
                job.word_c   = s_route_next_hop;
            end else if (pos_reg >= HDR_BYTES) begin
                // payload skip
                pos_next = (pos_inc >= {1'b0, len_reg}) ? '0 : pos_inc[LEN_W-1:0];
            end else begin
                if (pos_reg == POS_LEN_HI) begin
                    len_next = {s_data_byte, 8'h00};
                end else if (pos_reg == POS_LEN_LO) begin
                    len_next = {len_reg[15:8], s_data_byte};
                end else if (pos_reg == POS_TTL) begin
                    ttl_next = s_data_byte;
                end else if (pos_reg >= POS_SRC_LO && pos_reg <= POS_SRC_HI) begin
                    src_next = {src_reg[23:0], s_data_byte};
                end else if (pos_reg >= POS_DST_LO) begin
                    dst_next = {dst_reg[23:0], s_data_byte};
                end

                if (pos_reg == POS_LAST) begin
                    job_valid    = 1'b1;
                    job.is_route = 1'b0;
                    job.word_a   = src_reg;
                    job.word_b   = {dst_reg[23:0], s_data_byte};
                    job.ttl      = ttl_reg;
                    job.length   = len_reg;
                    pos_next     = (len_reg > HDR_BYTES) ? HDR_BYTES : '0;
                end else begin
                    pos_next = pos_inc[LEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            len_reg <= '0;
            ttl_reg <= '0;
            src_reg <= '0;
            dst_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            ttl_reg <= ttl_next;
            src_reg <= src_next;
            dst_reg <= dst_next;
        end
    end

endmodule

### hdl/ipv4rl_queue.sv
// ----------------------------------------------------------------------------
// ipv4rl_queue
// Short job queue that decouples the header parser from the lookup engine.
// ----------------------------------------------------------------------------
module ipv4rl_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  ipv4rl_pkg::job_t in_job,
    output logic             out_valid,
    input  logic             out_ready,
    output ipv4rl_pkg::job_t out_job
);
    import ipv4rl_pkg::*;

    job_t            slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic            push, pop;

    assign in_ready  = cnt_reg != (Q_AW + 1)'(Q_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_job   = slot_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + (Q_AW + 1)'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - (Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/ipv4rl_lookup.sv
// ----------------------------------------------------------------------------
// ipv4rl_lookup
// Back end: owns the route table, applies route writes in order and scans
// the valid entries for the longest matching prefix of each lookup job.
// ----------------------------------------------------------------------------
module ipv4rl_lookup #(
    parameter int ROUTES = ipv4rl_pkg::ROUTES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  ipv4rl_pkg::job_t                job,
    input  logic [ipv4rl_pkg::RCOUNT_W-1:0] route_count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ipv4rl_pkg::BYTE_W-1:0]   m_ttl_after,
    output logic [ipv4rl_pkg::ADDR_W-1:0]   m_source_address,
    output logic [ipv4rl_pkg::ADDR_W-1:0]   m_dest_address,
    output logic [ipv4rl_pkg::LEN_W-1:0]    m_packet_length,
    output logic                            m_dropped,
    output logic                            m_route_found,
    output logic [ipv4rl_pkg::ADDR_W-1:0]   m_next_hop
);
    import ipv4rl_pkg::*;

    localparam int AW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int CW = ($clog2(ROUTES + 1) > RCOUNT_W) ? $clog2(ROUTES + 1) : RCOUNT_W;

    route_t table_mem [ROUTES];
    route_t rd_data_reg;
    logic   rd_vld_reg;

    lookup_state_t state_reg, state_next;

    logic [CW-1:0]     addr_reg, addr_next;
    logic [CW-1:0]     limit;
    logic [BYTE_W-1:0] ttl_reg, ttl_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              drop_reg, drop_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] best_reg, best_next;
    logic [ADDR_W-1:0] hop_reg, hop_next;

    logic              out_vld_reg;
    logic [BYTE_W-1:0] out_ttl_reg;
    logic [ADDR_W-1:0] out_src_reg, out_dst_reg, out_hop_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_drop_reg, out_found_reg;

    logic take_job, wr_en, rd_en, load_out, job_drop, hit, out_free;

    assign limit    = (CW'(route_count) > CW'(ROUTES)) ? CW'(ROUTES) : CW'(route_count);
    assign job_drop = job.ttl <= 8'd1;
    assign out_free = !out_vld_reg || m_ready;
    assign take_job = job_valid && job_ready;
    assign hit      = rd_vld_reg && ((dst_reg & rd_data_reg.mask) == rd_data_reg.prefix)
                      && (!found_reg || rd_data_reg.mask >= best_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LK_IDLE: begin
                if (job_valid && !job.is_route) begin
                    state_next = (job_drop || limit == '0) ? LK_DONE : LK_SCAN;
                end
            end
            LK_SCAN: begin
                if (addr_reg == limit - CW'(1)) begin
                    state_next = LK_DRAIN;
                end
            end
            LK_DRAIN: begin
                state_next = LK_DONE;
            end
            LK_DONE: begin
                if (out_free) begin
                    state_next = LK_IDLE;
                end
            end
            default: begin
                state_next = LK_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        job_ready = 1'b0;
        rd_en     = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            LK_IDLE:  job_ready = 1'b1;
            LK_SCAN:  rd_en     = 1'b1;
            LK_DRAIN: rd_en     = 1'b0;
            LK_DONE:  load_out  = out_free;
            default:  job_ready = 1'b0;
        endcase
    end

    assign wr_en = take_job && job.is_route;

    // job and match bookkeeping
    always_comb begin
        addr_next  = addr_reg;
        ttl_next   = ttl_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        len_next   = len_reg;
        drop_next  = drop_reg;
        found_next = found_reg;
        best_next  = best_reg;
        hop_next   = hop_reg;
        if (take_job && !job.is_route) begin
            addr_next  = '0;
            ttl_next   = job.ttl;
            src_next   = job.word_a;
            dst_next   = job.word_b;
            len_next   = job.length;
            drop_next  = job_drop;
            found_next = 1'b0;
            best_next  = '0;
            hop_next   = '0;
        end else begin
            if (rd_en) begin
                addr_next = addr_reg + CW'(1);
            end
            // equal masks: the later entry wins
            if (hit) begin
                found_next = 1'b1;
                best_next  = rd_data_reg.mask;
                hop_next   = rd_data_reg.hop;
            end
        end
    end

    // route table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[AW'(job.index)] <= '{prefix: job.word_a, mask: job.word_b,
                                           hop: job.word_c};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= LK_IDLE;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            addr_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            found_reg  <= found_next;
            addr_reg   <= addr_next;
            if (load_out) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ttl_reg  <= ttl_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        len_reg  <= len_next;
        drop_reg <= drop_next;
        best_reg <= best_next;
        hop_reg  <= hop_next;
        if (load_out) begin
            out_ttl_reg   <= drop_reg ? '0 : ttl_reg - 8'd1;
            out_src_reg   <= src_reg;
            out_dst_reg   <= dst_reg;
            out_len_reg   <= len_reg;
            out_drop_reg  <= drop_reg;
            out_found_reg <= found_reg;
            out_hop_reg   <= found_reg ? hop_reg : '0;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_ttl_after      = out_ttl_reg;
    assign m_source_address = out_src_reg;
    assign m_dest_address   = out_dst_reg;
    assign m_packet_length  = out_len_reg;
    assign m_dropped        = out_drop_reg;
    assign m_route_found    = out_found_reg;
    assign m_next_hop       = out_hop_reg;

endmodule

### hdl/ipv4_header_route_lookup_core.sv
// Lookup: after the last header byte is taken, the job passes the job queue and
//   the engine scans N = min(route_count, ROUTES) entries; no scan when dropped or N = 0.
// Throughput: one byte or route write per cycle while the 4-entry job queue has
//   room; the lookup engine takes no new job until a header's result is loaded.
// Reset: synchronous, active low; clears parser, queue, engine and route_count;
//   the route table is not cleared.
// ----------------------------------------------------------------------------
// ipv4_header_route_lookup_core
// IPv4 header parser with longest-prefix-match next hop lookup.
// ----------------------------------------------------------------------------
module ipv4_header_route_lookup_core #(
    parameter int ROUTES = ipv4rl_pkg::ROUTES_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ipv4rl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [ipv4rl_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic [ipv4rl_pkg::RIDX_W-1:0]     s_route_index,
    input  logic [ipv4rl_pkg::ADDR_W-1:0]     s_route_prefix,
    input  logic [ipv4rl_pkg::ADDR_W-1:0]     s_route_mask,
    input  logic [ipv4rl_pkg::ADDR_W-1:0]     s_route_next_hop,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ipv4rl_pkg::BYTE_W-1:0]     m_ttl_after,
    output logic [ipv4rl_pkg::ADDR_W-1:0]     m_source_address,
    output logic [ipv4rl_pkg::ADDR_W-1:0]     m_dest_address,
    output logic [ipv4rl_pkg::LEN_W-1:0]      m_packet_length,
    output logic                              m_dropped,
    output logic                              m_route_found,
    output logic [ipv4rl_pkg::ADDR_W-1:0]     m_next_hop
);
    import ipv4rl_pkg::*;

    logic [RCOUNT_W-1:0] route_count_reg;
    logic                cfg_wr;

    logic  pq_valid, pq_ready;
    job_t  pq_job;
    logic  ql_valid, ql_ready;
    job_t  ql_job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_ROUTE_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_count_reg <= '0;
        end else if (cfg_wr) begin
            route_count_reg <= pwdata[RCOUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_ROUTE_COUNT) begin
            prdata = {{(32 - RCOUNT_W){1'b0}}, route_count_reg};
        end
    end

    ipv4rl_parser #(
        .ROUTES(ROUTES)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_data_byte     (s_data_byte),
        .s_route_index   (s_route_index),
        .s_route_prefix  (s_route_prefix),
        .s_route_mask    (s_route_mask),
        .s_route_next_hop(s_route_next_hop),
        .job_valid       (pq_valid),
        .job_ready       (pq_ready),
        .job             (pq_job)
    );

    ipv4rl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pq_valid),
        .in_ready (pq_ready),
        .in_job   (pq_job),
        .out_valid(ql_valid),
        .out_ready(ql_ready),
        .out_job  (ql_job)
    );

    ipv4rl_lookup #(
        .ROUTES(ROUTES)
    ) u_lookup (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (ql_valid),
        .job_ready       (ql_ready),
        .job             (ql_job),
        .route_count     (route_count_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_ttl_after     (m_ttl_after),
        .m_source_address(m_source_address),
        .m_dest_address  (m_dest_address),
        .m_packet_length (m_packet_length),
        .m_dropped       (m_dropped),
        .m_route_found   (m_route_found),
        .m_next_hop      (m_next_hop)
    );

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ipv4_header_route_lookup_core. Route writes and
// header/payload bytes go in through the input channel. Each transaction is
// run through a local parser and longest-prefix-match model when it is queued.
// Lookup results from the output channel are checked field by field, oldest
// first. route_count is written over APB between phases, only when idle.
// ----------------------------------------------------------------------------
module testbench;
    import ipv4rl_pkg::*;

    localparam int TABLE_SIZE  = ROUTES_DEFAULT;
    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 180;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
        logic [RIDX_W-1:0] idx;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] hop;
    } ingress_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ttl_after;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [LEN_W-1:0]  len;
        logic              dropped;
        logic              found;
        logic [ADDR_W-1:0] hop;
    } lookup_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_operation = OP_PACKET_BYTE;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic [RIDX_W-1:0] s_route_index = '0;
    logic [ADDR_W-1:0] s_route_prefix = '0;
    logic [ADDR_W-1:0] s_route_mask = '0;
    logic [ADDR_W-1:0] s_route_next_hop = '0;

    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_ttl_after;
    logic [ADDR_W-1:0] m_source_address;
    logic [ADDR_W-1:0] m_dest_address;
    logic [LEN_W-1:0]  m_packet_length;
    logic              m_dropped;
    logic              m_route_found;
    logic [ADDR_W-1:0] m_next_hop;

    // pending transactions and lookups still owed by the block
    ingress_item_t  ingress_q[$];
    lookup_result_t lookups_due_q[$];

    // parser and route table mirror
    bit [LEN_W-1:0]    hdr_pos;
    bit [LEN_W-1:0]    hdr_len;
    bit [BYTE_W-1:0]   hdr_ttl;
    bit [ADDR_W-1:0]   hdr_src;
    bit [ADDR_W-1:0]   hdr_dst;
    bit [RCOUNT_W-1:0] route_limit;
    bit [ADDR_W-1:0]   rt_prefix [TABLE_SIZE];
    bit [ADDR_W-1:0]   rt_mask [TABLE_SIZE];
    bit [ADDR_W-1:0]   rt_hop [TABLE_SIZE];

    bit          steady = 1'b0;
    bit          s_taken = 1'b0;
    int          items_queued = 0;
    int          results_seen = 0;
    int          errors = 0;
    int          hold_left = 0;
    int          next_hold = 10;
    int unsigned cycle_count = 0;

    ipv4_header_route_lookup_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_data_byte      (s_data_byte),
        .s_route_index    (s_route_index),
        .s_route_prefix   (s_route_prefix),
        .s_route_mask     (s_route_mask),
        .s_route_next_hop (s_route_next_hop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ttl_after      (m_ttl_after),
        .m_source_address (m_source_address),
        .m_dest_address   (m_dest_address),
        .m_packet_length  (m_packet_length),
        .m_dropped        (m_dropped),
        .m_route_found    (m_route_found),
        .m_next_hop       (m_next_hop)
    );

    always #HALF_PERIOD aclk = ~aclk;

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    function automatic lookup_result_t lookup_route();
        lookup_result_t r;
        bit [ADDR_W-1:0] best;
        bit hit;
        int n;
        n = (route_limit > TABLE_SIZE) ? TABLE_SIZE : route_limit;
        hit = 1'b0;
        best = '0;
        r.hop = '0;
        r.src = hdr_src;
        r.dst = hdr_dst;
        r.len = hdr_len;
        r.dropped = (hdr_ttl <= 8'd1);
        r.ttl_after = r.dropped ? 8'd0 : hdr_ttl - 8'd1;
        if (!r.dropped) begin
            for (int i = 0; i < n; i++) begin
                // later entry wins a tie on the mask
                if (((hdr_dst & rt_mask[i]) == rt_prefix[i]) && (!hit || rt_mask[i] >= best)) begin
                    hit = 1'b1;
                    best = rt_mask[i];
                    r.hop = rt_hop[i];
                end
            end
        end
        r.found = hit;
        return r;
    endfunction

    task automatic parse_and_route(input ingress_item_t it);
        bit [LEN_W-1:0] pos;
        pos = hdr_pos;
        if (it.op == OP_ROUTE_WRITE) begin
            rt_prefix[it.idx] = it.prefix;
            rt_mask[it.idx] = it.mask;
            rt_hop[it.idx] = it.hop;
        end else if (pos >= HDR_BYTES) begin
            // payload skip
            pos = pos + 1'b1;
            hdr_pos = (pos >= hdr_len) ? '0 : pos;
        end else begin
            if (pos == POS_LEN_HI)
                hdr_len = {it.data, 8'h00};
            else if (pos == POS_LEN_LO)
                hdr_len[7:0] = it.data;
            else if (pos == POS_TTL)
                hdr_ttl = it.data;
            else if (pos >= POS_SRC_LO && pos <= POS_SRC_HI)
                hdr_src = {hdr_src[23:0], it.data};
            else if (pos >= POS_DST_LO)
                hdr_dst = {hdr_dst[23:0], it.data};
            if (pos == POS_LAST) begin
                lookups_due_q.push_back(lookup_route());
                hdr_pos = (hdr_len > HDR_BYTES) ? HDR_BYTES : '0;
            end else begin
                hdr_pos = pos + 1'b1;
            end
        end
    endtask

    task automatic queue_item(input ingress_item_t it);
        ingress_q.push_back(it);
        parse_and_route(it);
        items_queued++;
    endtask

    task automatic queue_byte(input bit [BYTE_W-1:0] b);
        ingress_item_t it;
        it.op = OP_PACKET_BYTE;
        it.data = b;
        it.idx = RIDX_W'($urandom);
        it.prefix = $urandom;
        it.mask = $urandom;
        it.hop = $urandom;
        queue_item(it);
    endtask

    task automatic queue_route(input bit [RIDX_W-1:0] idx, input bit [ADDR_W-1:0] prefix,
                               input bit [ADDR_W-1:0] mask, input bit [ADDR_W-1:0] hop);
        ingress_item_t it;
        it.op = OP_ROUTE_WRITE;
        it.data = BYTE_W'($urandom);
        it.idx = idx;
        it.prefix = prefix;
        it.mask = mask;
        it.hop = hop;
        queue_item(it);
    endtask

    task automatic queue_random_route(input bit [RIDX_W-1:0] idx);
        bit [ADDR_W-1:0] m;
        bit [ADDR_W-1:0] p;
        int j;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
                m = ~(32'hFFFF_FFFF >> $urandom_range(32));
                p = $urandom & m;
            end
            6: begin
                m = $urandom;   // non-contiguous
                p = $urandom & m;
            end
            7: begin
                j = $urandom_range(TABLE_SIZE - 1);
                m = rt_mask[j];
                p = rt_prefix[j];
            end
            8: begin
                m = '0;
                p = '0;
            end
            default: begin
                m = $urandom;   // prefix bits outside the mask: almost never matches
                p = $urandom;
            end
        endcase
        queue_route(idx, p, m, $urandom);
    endtask

    function automatic bit [ADDR_W-1:0] pick_dest();
        int n;
        int j;
        n = (route_limit > TABLE_SIZE) ? TABLE_SIZE : route_limit;
        if (n != 0 && $urandom_range(9) < 7) begin
            j = $urandom_range(n - 1);
            return rt_prefix[j] | ($urandom & ~rt_mask[j]);
        end
        return $urandom;
    endfunction

    function automatic bit [BYTE_W-1:0] pick_ttl();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd2;
            3: return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic bit [LEN_W-1:0] pick_length();
        case ($urandom_range(9))
            0, 1: return LEN_W'($urandom_range(20));
            9: return LEN_W'($urandom_range(61, 600));
            default: return LEN_W'($urandom_range(21, 60));
        endcase
    endfunction

    // cut < 20 sends a truncated header, then zero bytes up to the next boundary
    task automatic queue_packet(input bit [BYTE_W-1:0] ttl, input bit [ADDR_W-1:0] src,
                                input bit [ADDR_W-1:0] dst, input bit [LEN_W-1:0] len,
                                input int cut, input bit sprinkle);
        bit [BYTE_W-1:0] hdr [HDR_BYTES];
        int pay;
        for (int i = 0; i < HDR_BYTES; i++)
            hdr[i] = BYTE_W'($urandom);
        hdr[POS_LEN_HI] = len[15:8];
        hdr[POS_LEN_LO] = len[7:0];
        hdr[POS_TTL] = ttl;
        for (int i = 0; i < 4; i++) begin
            hdr[POS_SRC_LO + i] = src[31 - 8*i -: 8];
            hdr[POS_DST_LO + i] = dst[31 - 8*i -: 8];
        end
        for (int i = 0; i < cut; i++) begin
            if (sprinkle && $urandom_range(15) == 0)
                queue_random_route(RIDX_W'($urandom));
            queue_byte(hdr[i]);
        end
        if (cut < HDR_BYTES) begin
            while (hdr_pos != 0)
                queue_byte(8'h00);
        end else begin
            pay = (len > HDR_BYTES) ? len - HDR_BYTES : 0;
            repeat (pay) queue_byte(BYTE_W'($urandom));
        end
    endtask

    // waits until the sender is empty and everything owed has come back, then lets queued
    // route writes retire before any register access
    task automatic settle();
        @(negedge aclk);
        while (ingress_q.size() != 0 || s_valid || lookups_due_q.size() != 0)
            @(negedge aclk);
        repeat (TABLE_SIZE + 8) @(negedge aclk);
    endtask

    task automatic set_route_count(input bit [RCOUNT_W-1:0] n);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = REG_ROUTE_COUNT;
        pwdata = 32'(n);
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        route_limit = n;
        @(negedge aclk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== 32'(n))
            report_mismatch($sformatf("route_count reads %0h, wrote %0h", prdata, n));
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk)
        s_taken <= s_valid && s_ready;

    always @(negedge aclk) begin : ingress_driver
        ingress_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (ingress_q.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
                it = ingress_q.pop_front();
                s_valid <= 1'b1;
                s_operation <= it.op;
                s_data_byte <= it.data;
                s_route_index <= it.idx;
                s_route_prefix <= it.prefix;
                s_route_mask <= it.mask;
                s_route_next_hop <= it.hop;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long hold-offs only while the sender still has plenty to offer
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!steady && results_seen >= next_hold && ingress_q.size() > 40) begin
            m_ready <= 1'b0;
            hold_left <= 300;
            next_hold <= results_seen + 40;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 37);
        end
    end

    always @(posedge aclk) begin : result_monitor
        lookup_result_t want;
        string diff;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (lookups_due_q.size() == 0) begin
                report_mismatch("lookup result transaction with nothing outstanding");
            end else begin
                want = lookups_due_q.pop_front();
                diff = "";
                if (m_ttl_after !== want.ttl_after)
                    diff = {diff, $sformatf(" ttl %0d/%0d", m_ttl_after, want.ttl_after)};
                if (m_source_address !== want.src)
                    diff = {diff, $sformatf(" src %h/%h", m_source_address, want.src)};
                if (m_dest_address !== want.dst)
                    diff = {diff, $sformatf(" dst %h/%h", m_dest_address, want.dst)};
                if (m_packet_length !== want.len)
                    diff = {diff, $sformatf(" len %0d/%0d", m_packet_length, want.len)};
                if (m_dropped !== want.dropped)
                    diff = {diff, $sformatf(" dropped %b/%b", m_dropped, want.dropped)};
                if (m_route_found !== want.found)
                    diff = {diff, $sformatf(" found %b/%b", m_route_found, want.found)};
                if (m_next_hop !== want.hop)
                    diff = {diff, $sformatf(" hop %h/%h", m_next_hop, want.hop)};
                if (diff != "")
                    report_mismatch({"lookup (got/exp):", diff});
            end
        end
    end

    initial begin
        bit [RCOUNT_W-1:0] n;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table: drops at TTL 0 and 1, miss on a header with length 0
        queue_packet(8'd0, 32'h0102_0304, 32'h0A01_0203, 16'd20, HDR_BYTES, 1'b0);
        queue_packet(8'd1, 32'h0102_0304, 32'h0A01_0203, 16'd21, HDR_BYTES, 1'b0);
        queue_packet(8'd2, 32'h0, 32'hFFFF_FFFF, 16'd0, HDR_BYTES, 1'b0);

        // table: default route, /8, tied /16 pair, host route,
        // non-contiguous mask, unmatchable prefix, then random entries
        queue_route(6'd0, 32'h0, 32'h0, 32'hDEF0_0001);
        queue_route(6'd1, 32'h0A00_0000, 32'hFF00_0000, 32'h0800_0001);
        queue_route(6'd2, 32'h0A01_0000, 32'hFFFF_0000, 32'h1600_0002);
        queue_route(6'd3, 32'h0A01_0000, 32'hFFFF_0000, 32'h1600_0003);
        queue_route(6'd4, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h3200_0004);
        queue_route(6'd5, 32'h0A00_0300, 32'hFF00_FF00, 32'hACAC_0005);
        queue_route(6'd6, 32'h0A00_00FF, 32'hFF00_0000, 32'hBADB_0006);
        for (int i = 7; i < TABLE_SIZE; i++)
            queue_random_route(RIDX_W'(i));
        settle();
        set_route_count(7'd64);

        queue_packet(8'd64, $urandom, 32'h0A01_0203, 16'd40, HDR_BYTES, 1'b0);
        queue_packet(8'd64, $urandom, 32'h0A01_FFFF, 16'd20, HDR_BYTES, 1'b0);
        queue_packet(8'd64, $urandom, 32'h0A02_0304, 16'd22, HDR_BYTES, 1'b0);
        queue_packet(8'd64, $urandom, 32'hC0A8_0001, 16'd5, HDR_BYTES, 1'b0);
        queue_packet(8'd2, 32'h0, 32'hFFFF_FFFF, 16'd20, 10, 1'b0);
        // long payload, streamed back to back
        steady = 1'b1;
        queue_packet(8'hFF, 32'hFFFF_FFFF, 32'h0, 16'd300, HDR_BYTES, 1'b0);
        settle();
        steady = 1'b0;

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: n = 7'd127;   // above the table size
                1: n = 7'd1;
                2: n = 7'd0;
                3: n = 7'd65;
                4: n = 7'd64;
                default: n = RCOUNT_W'($urandom_range(127));
            endcase
            settle();
            set_route_count(n);
            steady = (p == 4);
            for (int start = items_queued; items_queued - start < PHASE_ITEMS; ) begin
                case ($urandom_range(9))
                    0: queue_random_route(RIDX_W'($urandom));
                    1: queue_packet(pick_ttl(), $urandom, pick_dest(), pick_length(),
                                    $urandom_range(1, 19), 1'b1);
                    2, 3: queue_packet(pick_ttl(), $urandom, pick_dest(), pick_length(),
                                       HDR_BYTES, 1'b1);
                    default: queue_packet(pick_ttl(), $urandom, pick_dest(), pick_length(),
                                          HDR_BYTES, 1'b0);
                endcase
            end
        end
        settle();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
